// ===== hdl/assert_macros.svh =====
// Assertion helpers; every use is clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QBUT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QBUT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qbut_pkg.sv =====
package qbut_pkg;

    localparam int IMAGE_SIDE_LOG2_DEF = 6;

    localparam int COORD_W = 6;
    localparam int CHAN_W  = 8;
    localparam int SLOG_W  = 3;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int ERR_W   = 16;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIV_W   = SQ_W + 2;

    // reciprocal of three, scaled by 2**RECIP3_SH and rounded up
    localparam int                  RECIP3_W  = DIV_W;
    localparam int                  RECIP3_SH = DIV_W + 1;
    localparam logic [RECIP3_W-1:0] RECIP3    = RECIP3_W'((2 ** RECIP3_SH + 2) / 3);

    localparam logic [ERR_W-1:0] ERR_MAX = 16'd65025;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [SLOG_W-1:0]  side_log2;
    } in_item_t;

    typedef struct packed {
        logic              is_leaf;
        logic [CHAN_W-1:0] mean_red;
        logic [CHAN_W-1:0] mean_green;
        logic [CHAN_W-1:0] mean_blue;
        logic [ERR_W-1:0]  block_error;
        logic              bad_block;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic sum_en;
        logic mean_en;
        logic sq_en;
    } stats_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_DRAIN,
        S_MEAN,
        S_ERR_RD,
        S_ERR_DRAIN,
        S_ERR_TAIL,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_OUT
    } state_t;

endpackage

// ===== hdl/qbut_pixel_mem.sv =====
module qbut_pixel_mem
    import qbut_pkg::*;
#(
    parameter int ADDR_W = 2 * IMAGE_SIDE_LOG2_DEF
)
(
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [PIX_W-1:0]  wdata,
    output logic [PIX_W-1:0]  rdata
);

    logic [PIX_W-1:0] mem [2**ADDR_W];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/qbut_stats.sv =====
module qbut_stats
    import qbut_pkg::*;
#(
    parameter int IMAGE_SIDE_LOG2 = IMAGE_SIDE_LOG2_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  stats_ctrl_t       ctrl,
    input  logic [PIX_W-1:0]  pixel,
    input  logic [SLOG_W-1:0] slog,
    output logic [CHAN_W-1:0] mean_red,
    output logic [CHAN_W-1:0] mean_green,
    output logic [CHAN_W-1:0] mean_blue,
    output logic [DIV_W-1:0]  score_avg
);

    localparam int SUM_W   = CHAN_W + 2 * IMAGE_SIDE_LOG2;
    localparam int SCORE_W = DIV_W + 2 * IMAGE_SIDE_LOG2;

    logic [SUM_W-1:0]   sum_reg   [3];
    logic [SUM_W-1:0]   sum_next  [3];
    logic [CHAN_W-1:0]  mean_reg  [3];
    logic [CHAN_W-1:0]  mean_next [3];
    logic [SQ_W-1:0]    sq_reg    [3];
    logic [SQ_W-1:0]    sq_next   [3];
    logic               sq_vld_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    logic [SCORE_W-1:0] score_shift;
    logic [DIV_W-1:0]   sq_sum;

    always_comb
    begin
        logic [CHAN_W-1:0] v;
        logic [CHAN_W-1:0] d;
        logic [SUM_W-1:0]  shifted;
        for (int ch = 0; ch < 3; ch++)
        begin
            v = pixel[PIX_W-1-CHAN_W*ch -: CHAN_W];
            sum_next[ch] = sum_reg[ch] + SUM_W'(v);
            shifted = sum_reg[ch] >> {slog, 1'b0};
            mean_next[ch] = shifted[CHAN_W-1:0];
            d = (v > mean_reg[ch]) ? (v - mean_reg[ch]) : (mean_reg[ch] - v);
            sq_next[ch] = SQ_W'(d) * SQ_W'(d);
        end
        sq_sum = DIV_W'(sq_reg[0]) + DIV_W'(sq_reg[1]) + DIV_W'(sq_reg[2]);
        score_next = score_reg + SCORE_W'(sq_sum);
        score_shift = score_reg >> {slog, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg <= ctrl.sq_en;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (ctrl.clear)
            begin
                sum_reg[ch] <= '0;
            end
            else if (ctrl.sum_en)
            begin
                sum_reg[ch] <= sum_next[ch];
            end
            if (ctrl.mean_en)
            begin
                mean_reg[ch] <= mean_next[ch];
            end
            if (ctrl.sq_en)
            begin
                sq_reg[ch] <= sq_next[ch];
            end
        end
        if (ctrl.clear)
        begin
            score_reg <= '0;
        end
        else if (sq_vld_reg)
        begin
            score_reg <= score_next;
        end
    end

    assign mean_red   = mean_reg[0];
    assign mean_green = mean_reg[1];
    assign mean_blue  = mean_reg[2];
    assign score_avg  = score_shift[DIV_W-1:0];

endmodule

// ===== hdl/qbut_div3.sv =====
module qbut_div3
    import qbut_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [DIV_W-1:0] dividend,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    localparam int PROD_W = DIV_W + RECIP3_W;

    logic              run_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  q_reg;
    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(dvd_reg) * PROD_W'(RECIP3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg <= dividend;
        end
        if (run_reg)
        begin
            q_reg <= DIV_W'(prod >> RECIP3_SH);
        end
    end

    assign busy     = run_reg;
    assign quotient = q_reg;

endmodule

// ===== hdl/quadtree_block_uniformity_test_core.sv =====
// Pixel write: accepted while idle, no result; writes may follow back to back.
// Query inside the image: result strobed after two passes over the block through the
// registered pixel memory and then a divide by three.
// Query past the image edge: result strobed in the cycle after acceptance.
// busy holds the next item off until the cycle after the strobe; the receiver cannot stall.
// Reset clears control state and the threshold; pixel memory holds no reset value.
module quadtree_block_uniformity_test_core
    import qbut_pkg::*;
#(
    parameter int IMAGE_SIDE_LOG2 = IMAGE_SIDE_LOG2_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         item,
    output logic             done,
    output out_item_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [ERR_W-1:0] cfg_data
);

    localparam int L      = IMAGE_SIDE_LOG2;
    localparam int ADDR_W = 2 * L;
    localparam int EXT_W  = ((L > COORD_W + 1) ? L : COORD_W + 1) + 2;

    state_t            state_reg;
    state_t            state_next;
    logic [ERR_W-1:0]  thr_reg;
    logic [L-1:0]      roff_reg;
    logic [L-1:0]      roff_next;
    logic [L-1:0]      coff_reg;
    logic [L-1:0]      coff_next;
    logic [L-1:0]      brow_reg;
    logic [L-1:0]      bcol_reg;
    logic [L-1:0]      mask_reg;
    logic [SLOG_W-1:0] slog_reg;
    logic              rd_vld_reg;
    out_item_t         result_reg;
    out_item_t         result_next;
    logic              result_ld;

    logic [EXT_W-1:0]  row_e;
    logic [EXT_W-1:0]  col_e;
    logic [EXT_W-1:0]  side_e;
    logic [EXT_W-1:0]  img_e;
    logic              in_image;
    logic              off_edge;
    logic              accept;
    logic              last_pix;
    logic              reading;

    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [PIX_W-1:0]  mem_rdata;
    stats_ctrl_t       sctrl;
    logic [CHAN_W-1:0] mean_r;
    logic [CHAN_W-1:0] mean_g;
    logic [CHAN_W-1:0] mean_b;
    logic [DIV_W-1:0]  score_avg;
    logic              div_load;
    logic              div_busy;
    logic [DIV_W-1:0]  quotient;
    logic [ERR_W-1:0]  err_sat;

    assign row_e    = EXT_W'(item.row);
    assign col_e    = EXT_W'(item.col);
    assign side_e   = EXT_W'(1) << item.side_log2;
    assign img_e    = EXT_W'(1) << L;
    assign in_image = (row_e < img_e) && (col_e < img_e);
    assign off_edge = ((row_e + side_e) > img_e) || ((col_e + side_e) > img_e);
    assign accept   = start && !busy;
    assign last_pix = (roff_reg == mask_reg) && (coff_reg == mask_reg);
    assign reading  = (state_reg == S_SUM_RD) || (state_reg == S_ERR_RD);
    assign err_sat  = (|quotient[DIV_W-1:ERR_W]) ? {ERR_W{1'b1}} : quotient[ERR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && item.kind == KIND_QUERY)
                begin
                    state_next = off_edge ? S_OUT : S_SUM_RD;
                end
            end
            S_SUM_RD:    state_next = last_pix ? S_SUM_DRAIN : S_SUM_RD;
            S_SUM_DRAIN: state_next = S_MEAN;
            S_MEAN:      state_next = S_ERR_RD;
            S_ERR_RD:    state_next = last_pix ? S_ERR_DRAIN : S_ERR_RD;
            S_ERR_DRAIN: state_next = S_ERR_TAIL;
            S_ERR_TAIL:  state_next = S_DIV_LOAD;
            S_DIV_LOAD:  state_next = S_DIV_RUN;
            S_DIV_RUN:   state_next = div_busy ? S_DIV_RUN : S_OUT;
            S_OUT:       state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        done          = (state_reg == S_OUT);
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = {brow_reg + roff_reg, bcol_reg + coff_reg};
        sctrl.clear   = 1'b0;
        sctrl.sum_en  = 1'b0;
        sctrl.mean_en = 1'b0;
        sctrl.sq_en   = 1'b0;
        div_load      = 1'b0;
        result_ld     = 1'b0;
        result_next   = '0;
        roff_next     = roff_reg;
        coff_next     = coff_reg;
        if (reading)
        begin
            mem_en = 1'b1;
            if (coff_reg == mask_reg)
            begin
                coff_next = '0;
                roff_next = roff_reg + 1'b1;
            end
            else
            begin
                coff_next = coff_reg + 1'b1;
            end
        end
        unique case (state_reg)
            S_IDLE:
            begin
                sctrl.clear = 1'b1;
                roff_next   = '0;
                coff_next   = '0;
                mem_addr    = {L'(item.row), L'(item.col)};
                if (accept && item.kind == KIND_WRITE && in_image)
                begin
                    mem_en = 1'b1;
                    mem_we = 1'b1;
                end
                if (accept && item.kind == KIND_QUERY && off_edge)
                begin
                    result_ld             = 1'b1;
                    result_next.bad_block = 1'b1;
                end
            end
            S_SUM_RD, S_SUM_DRAIN:
            begin
                sctrl.sum_en = rd_vld_reg;
            end
            S_MEAN:
            begin
                sctrl.mean_en = 1'b1;
                roff_next     = '0;
                coff_next     = '0;
            end
            S_ERR_RD, S_ERR_DRAIN:
            begin
                sctrl.sq_en = rd_vld_reg;
            end
            S_DIV_LOAD:
            begin
                div_load = 1'b1;
            end
            S_DIV_RUN:
            begin
                result_ld              = !div_busy;
                result_next.is_leaf    = (err_sat <= thr_reg);
                result_next.mean_red   = mean_r;
                result_next.mean_green = mean_g;
                result_next.mean_blue  = mean_b;
                result_next.block_error = err_sat;
            end
            S_ERR_TAIL, S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            thr_reg    <= '0;
            roff_reg   <= '0;
            coff_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            roff_reg   <= roff_next;
            coff_reg   <= coff_next;
            rd_vld_reg <= reading;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            brow_reg <= L'(item.row);
            bcol_reg <= L'(item.col);
            mask_reg <= L'(side_e - EXT_W'(1));
            slog_reg <= item.side_log2;
        end
        if (result_ld)
        begin
            result_reg <= result_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign result    = result_reg;

    qbut_pixel_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata ({item.red, item.green, item.blue}),
        .rdata (mem_rdata)
    );

    qbut_stats #(
        .IMAGE_SIDE_LOG2 (IMAGE_SIDE_LOG2)
    ) u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (sctrl),
        .pixel      (mem_rdata),
        .slog       (slog_reg),
        .mean_red   (mean_r),
        .mean_green (mean_g),
        .mean_blue  (mean_b),
        .score_avg  (score_avg)
    );

    qbut_div3 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (score_avg),
        .busy     (div_busy),
        .quotient (quotient)
    );

endmodule

// ===== hdl/qbut_checker.sv =====
`include "assert_macros.svh"

module qbut_sva
    import qbut_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input in_item_t         item,
    input logic             done,
    input out_item_t        result
);

    `QBUT_ASSERT_NOW(a_done_busy, done, busy, "result strobe while idle")

    `QBUT_ASSERT_NEXT(a_done_ends, done, !done && !busy, "result strobe not followed by idle")

    `QBUT_ASSERT_NEXT(a_query_busy, start && !busy && item.kind == KIND_QUERY, busy,
        "query item did not start work")

    `QBUT_ASSERT_NOW(a_bad_zero, done && result.bad_block,
        !result.is_leaf && result.block_error == '0 && result.mean_red == '0,
        "edge result carries data")

    `QBUT_ASSERT_NOW(a_err_range, done && !result.bad_block, result.block_error <= ERR_MAX,
        "block error out of range")

endmodule

bind quadtree_block_uniformity_test_core qbut_sva u_qbut_sva (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result)
);

// ===== tb/sv/qbut_checker.sv =====
`timescale 1ns / 1ps

module qbut_checker
    import qbut_pkg::*;
#(
    parameter int IMAGE_SIDE_LOG2 = IMAGE_SIDE_LOG2_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  in_item_t         item,
    input  logic             done,
    input  out_item_t        result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [ERR_W-1:0] cfg_data,
    output int               mismatches,
    output int               pending
);

    localparam int IMAGE_SIDE = 1 << IMAGE_SIDE_LOG2;

    logic [PIX_W-1:0] image_mem [IMAGE_SIDE*IMAGE_SIDE];
    logic [ERR_W-1:0] split_threshold;
    out_item_t        block_stats_q [$];
    int               error_tally;

    function automatic out_item_t predict_block_stats(input in_item_t q);
        out_item_t        r;
        int               side;
        int               y;
        int               x;
        int               ch;
        longint unsigned  n;
        longint unsigned  sq_sum;
        longint unsigned  err;
        longint unsigned  d;
        longint unsigned  ch_sum [3];
        int unsigned      ch_mean [3];
        int unsigned      v;
        logic [PIX_W-1:0] px;
        r = '0;
        side = 1 << q.side_log2;
        if (q.row + side > IMAGE_SIDE || q.col + side > IMAGE_SIDE)
        begin
            r.bad_block = 1'b1;
            return r;
        end
        n = side * side;
        for (ch = 0; ch < 3; ch++)
        begin
            ch_sum[ch] = 0;
        end
        for (y = q.row; y < q.row + side; y++)
        begin
            for (x = q.col; x < q.col + side; x++)
            begin
                px = image_mem[y * IMAGE_SIDE + x];
                for (ch = 0; ch < 3; ch++)
                begin
                    ch_sum[ch] += px[PIX_W-1-CHAN_W*ch -: CHAN_W];
                end
            end
        end
        for (ch = 0; ch < 3; ch++)
        begin
            ch_mean[ch] = 32'(ch_sum[ch] / n);
        end
        sq_sum = 0;
        for (y = q.row; y < q.row + side; y++)
        begin
            for (x = q.col; x < q.col + side; x++)
            begin
                px = image_mem[y * IMAGE_SIDE + x];
                for (ch = 0; ch < 3; ch++)
                begin
                    v = px[PIX_W-1-CHAN_W*ch -: CHAN_W];
                    d = (v > ch_mean[ch]) ? v - ch_mean[ch] : ch_mean[ch] - v;
                    sq_sum += d * d;
                end
            end
        end
        err = sq_sum / (3 * n);
        if (err > 65535)
        begin
            err = 65535;
        end
        r.is_leaf     = (err <= split_threshold);
        r.mean_red    = CHAN_W'(ch_mean[0]);
        r.mean_green  = CHAN_W'(ch_mean[1]);
        r.mean_blue   = CHAN_W'(ch_mean[2]);
        r.block_error = ERR_W'(err);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            error_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_stats;
        if (!rst_n)
        begin
            split_threshold = '0;
            block_stats_q.delete();
            error_tally = 0;
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                split_threshold = cfg_data;
            end
            if (done)
            begin
                if (block_stats_q.size() == 0)
                begin
                    $error("result with no query outstanding");
                    error_tally++;
                end
                else
                begin
                    exp_stats = block_stats_q.pop_front();
                    check_field("is_leaf", exp_stats.is_leaf, result.is_leaf);
                    check_field("mean_red", exp_stats.mean_red, result.mean_red);
                    check_field("mean_green", exp_stats.mean_green, result.mean_green);
                    check_field("mean_blue", exp_stats.mean_blue, result.mean_blue);
                    check_field("block_error", exp_stats.block_error, result.block_error);
                    check_field("bad_block", exp_stats.bad_block, result.bad_block);
                end
            end
            if (start && !busy)
            begin
                if (item.kind == KIND_QUERY)
                begin
                    block_stats_q.push_back(predict_block_stats(item));
                end
                else if (item.row < IMAGE_SIDE && item.col < IMAGE_SIDE)
                begin
                    image_mem[item.row * IMAGE_SIDE + item.col] =
                        {item.red, item.green, item.blue};
                end
            end
            pending    <= block_stats_q.size();
            mismatches <= error_tally;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import qbut_pkg::*;

    localparam int IMAGE_SIDE  = 1 << IMAGE_SIDE_LOG2_DEF;
    localparam int TILE_SIDE   = 4;
    localparam int TILES       = IMAGE_SIDE / TILE_SIDE;
    localparam int REGION      = 8;
    localparam int STALL_LIMIT = 40000;

    typedef enum logic [1:0] {
        TILE_FLAT,
        TILE_GRAINY,
        TILE_NOISY
    } tile_mode_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    in_item_t         item;
    logic             done;
    out_item_t        result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [ERR_W-1:0] cfg_data;
    int               mismatches;
    int               pending;
    int               idle_pct;
    int               stall_cycles;
    logic [PIX_W-1:0] tile_color [TILES*TILES];
    tile_mode_t       tile_mode [TILES*TILES];

    quadtree_block_uniformity_test_core #(
        .IMAGE_SIDE_LOG2(IMAGE_SIDE_LOG2_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    qbut_checker #(
        .IMAGE_SIDE_LOG2(IMAGE_SIDE_LOG2_DEF)
    ) block_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic in_item_t pixel_item(input int row, input int col);
        in_item_t it;
        int       t;
        t = (row / TILE_SIDE) * TILES + (col / TILE_SIDE);
        it = in_item_t'($urandom);
        it.kind = KIND_WRITE;
        it.row  = COORD_W'(row);
        it.col  = COORD_W'(col);
        unique case (tile_mode[t])
            TILE_FLAT:   {it.red, it.green, it.blue} = tile_color[t];
            TILE_GRAINY: {it.red, it.green, it.blue} =
                             (tile_color[t] & 24'hFCFCFC) | PIX_W'($urandom & 24'h030303);
            default:     {it.red, it.green, it.blue} = PIX_W'($urandom);
        endcase
        return it;
    endfunction

    function automatic in_item_t query_item(input int row, input int col, input int slog);
        in_item_t it;
        it = in_item_t'($urandom);
        it.kind      = KIND_QUERY;
        it.row       = COORD_W'(row);
        it.col       = COORD_W'(col);
        it.side_log2 = SLOG_W'(slog);
        return it;
    endfunction

    function automatic in_item_t random_item();
        int pick;
        int slog;
        int side;
        int row;
        int col;
        int tmp;
        if ($urandom_range(99) < 35)
        begin
            return pixel_item($urandom_range(REGION - 1), $urandom_range(REGION - 1));
        end
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            slog = (pick < 5) ? 7 : $urandom_range(6, 1);
            side = 1 << slog;
            row  = $urandom_range(IMAGE_SIDE - 1);
            col  = (slog == 7) ? $urandom_range(IMAGE_SIDE - 1) :
                   $urandom_range(IMAGE_SIDE - 1, IMAGE_SIDE - side + 1);
            if ($urandom_range(1) == 1)
            begin
                tmp = row;
                row = col;
                col = tmp;
            end
            return query_item(row, col, slog);
        end
        slog = $urandom_range(3);
        side = 1 << slog;
        row  = $urandom_range(REGION - side);
        col  = $urandom_range(REGION - side);
        if ($urandom_range(99) < 80)
        begin
            row = (row >> slog) << slog;
            col = (col >> slog) << slog;
        end
        return query_item(row, col, slog);
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic paint(input int row, input int col, input logic [PIX_W-1:0] color);
        in_item_t it;
        it = pixel_item(row, col);
        {it.red, it.green, it.blue} = color;
        send_item(it);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [ERR_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int pick;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        idle_pct  = 6;
        for (int t = 0; t < TILES * TILES; t++)
        begin
            tile_color[t] = PIX_W'($urandom);
            tile_mode[t]  = tile_mode_t'($urandom_range(2));
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_threshold('0);

        // load the region that block queries read
        for (int y = 0; y < REGION; y++)
        begin
            for (int x = 0; x < REGION; x++)
            begin
                send_item(pixel_item(y, x));
            end
        end

        paint(0, 0, 24'h000000);
        paint(0, 1, 24'hFFFFFF);
        paint(1, 0, 24'hFFFFFF);
        paint(1, 1, 24'h000000);
        send_item(query_item(0, 0, 0));
        send_item(query_item(0, 0, 1));
        paint(0, 2, 24'hFFFFFF);
        paint(0, 3, 24'hFFFFFF);
        paint(1, 2, 24'hFFFFFF);
        paint(1, 3, 24'hFFFFFF);
        send_item(query_item(0, 2, 1));
        paint(IMAGE_SIDE - 2, IMAGE_SIDE - 2, 24'h102030);
        paint(IMAGE_SIDE - 2, IMAGE_SIDE - 1, 24'hF0E0D0);
        paint(IMAGE_SIDE - 1, IMAGE_SIDE - 2, 24'h7F8081);
        paint(IMAGE_SIDE - 1, IMAGE_SIDE - 1, 24'h5AA5C3);
        send_item(query_item(IMAGE_SIDE - 2, IMAGE_SIDE - 2, 1));
        send_item(query_item(IMAGE_SIDE - 1, IMAGE_SIDE - 1, 0));
        send_item(query_item(IMAGE_SIDE - 1, IMAGE_SIDE - 1, 1));
        send_item(query_item(0, 0, 7));
        send_item(query_item(4, 4, 2));
        send_item(query_item(33, 32, 5));
        send_item(query_item(0, IMAGE_SIDE - 1, 1));
        send_item(query_item(0, 0, 3));
        write_threshold(16'hFFFF);
        send_item(query_item(0, 0, 1));
        write_threshold(16'd16256);
        send_item(query_item(0, 0, 1));
        write_threshold(16'd16255);
        send_item(query_item(0, 0, 1));

        for (int phase = 0; phase < 3; phase++)
        begin
            for (int n = 0; n < 8; n++)
            begin
                if (n % 4 == 0)
                begin
                    pick = $urandom_range(99);
                    write_threshold((pick < 10) ? 16'hFFFF :
                                    (pick < 20) ? 16'h0000 : 16'($urandom_range(4000)));
                    idle_pct = (phase == 0) ? 6 : (phase == 1) ? 74 : 0;
                end
                send_item(random_item());
            end
        end

        wait_idle();
        repeat (30) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
